// File: rtl/pwmre_pkg.sv
// Package: function codes, register map constants and shared types of the PWM register emulator.
`default_nettype none
package pwmre_pkg;

	typedef enum logic [1:0] {
		FUNC_SET_PTR = 2'd0,
		FUNC_DATA    = 2'd1,
		FUNC_READ    = 2'd2,
		FUNC_QUERY   = 2'd3
	} func_t;

	localparam logic [7:0] ADDR_MODE1        = 8'h00;
	localparam logic [7:0] ADDR_MODE2        = 8'h01;
	localparam logic [7:0] ADDR_PRESCALE     = 8'h05;
	localparam logic [7:0] ADDR_CH_BASE      = 8'h06;
	localparam logic [7:0] ADDR_PRESCALE_BUS = 8'hFE;
	localparam logic [7:0] READ_MISS         = 8'hFF;
	localparam logic [15:0] PULSE_INVALID    = 16'hFFFF;

	localparam int SLEEP_BIT  = 4;
	localparam int OUTDRV_BIT = 2;

	// (x * PULSE_RECIP) >> PULSE_RECIP_SHIFT equals x / 25 for every 32-bit x
	localparam logic [31:0] PULSE_RECIP       = 32'h51EB851F;
	localparam int          PULSE_RECIP_SHIFT = 35;

	typedef struct packed {
		logic [15:0] on_count;
		logic [15:0] off_count;
		logic [7:0]  prescale;
	} pulse_req_t;

endpackage
`default_nettype wire

// File: rtl/pwmre_pulse.sv
// Pulse width unit: (off - on) * (prescale + 1) / 25 with a multiply step and a reciprocal divide.
`default_nettype none
module pwmre_pulse (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire pwmre_pkg::pulse_req_t req,
	output logic                       done,
	output logic [15:0]                pulse
);

	typedef enum logic [1:0] {
		P_IDLE,
		P_MUL,
		P_DIV
	} pstate_t;

	pstate_t     state_q;
	logic [31:0] diff_q;
	logic [8:0]  scale_q;
	logic [31:0] quo_q;
	logic        done_q;

	logic [63:0] recip;

	assign recip = {32'd0, quo_q} * {32'd0, pwmre_pkg::PULSE_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			diff_q  <= '0;
			scale_q <= '0;
			quo_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						// wraps in 32 bits when off is below on
						diff_q  <= {16'd0, req.off_count} - {16'd0, req.on_count};
						scale_q <= {1'b0, req.prescale} + 9'd1;
						state_q <= P_MUL;
					end
				end
				P_MUL: begin
					quo_q   <= 32'(diff_q * {23'd0, scale_q});
					state_q <= P_DIV;
				end
				P_DIV: begin
					// divide by 25 through the reciprocal multiply
					quo_q   <= 32'(recip >> pwmre_pkg::PULSE_RECIP_SHIFT);
					done_q  <= 1'b1;
					state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign pulse = quo_q[15:0];

endmodule
`default_nettype wire

// File: rtl/pwm_controller_register_emulator.sv
// Top level: PWM controller register emulator with a byte-wide register file memory.
// One transaction in, one transaction out. Pointer set and data write answer in the
// cycle after acceptance; a read goes through the registered read port of the register
// file; a query for a valid channel makes seven byte fetches from the single read port,
// then a multiply, a reciprocal multiply for the divide by 25 and a register of the
// result. With the sleep bit set or output drive clear the query ends after the seven
// fetches. A query for an invalid channel answers in the cycle after acceptance.
// The next transaction is taken once the previous one has finished and the result
// register is free or being read.
// The register file reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed.
`default_nettype none
module pwm_controller_register_emulator #(
	parameter int CHANNELS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  channel,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [7:0]       read_data,
	output logic [15:0]      pulse_us,
	output logic             write_seen
);

	localparam int FILE_BYTES = 6 + 4 * CHANNELS;
	localparam int ADDR_W     = $clog2(FILE_BYTES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FETCH,
		S_CALC
	} state_t;

	state_t      state_q;
	logic [7:0]  ptr_q;
	logic        flag_q;
	logic        seen_q;
	logic [5:0]  ch_q;
	logic [2:0]  step_q;
	logic        sleep_q;
	logic        outdrv_q;
	logic [7:0]  ps_q;
	logic [15:0] on_q;
	logic [7:0]  off_lo_q;

	logic        rsp_valid_q;
	logic [7:0]  read_data_q;
	logic [15:0] pulse_us_q;
	logic        write_seen_q;

	// register file and its reset-valid bits
	logic [7:0]            mem [FILE_BYTES];
	logic [FILE_BYTES-1:0] valid_q;
	logic [7:0]            rdata_s1;
	logic                  rvalid_s1;

	logic              accept;
	logic              ptr_in_file;
	logic              ch_ok;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr;
	logic              mem_re;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        fetch_addr;
	logic [7:0]        rd_byte;

	pwmre_pkg::pulse_req_t preq;
	logic                  pstart;
	logic                  pdone;
	logic [15:0]           pvalue;

	assign req_ready   = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept      = req_valid && req_ready;
	assign ptr_in_file = ptr_q < 8'(FILE_BYTES);
	assign ch_ok       = channel < 8'(CHANNELS);
	assign rd_byte     = rvalid_s1 ? rdata_s1 : 8'd0;

	always_comb begin
		unique case (step_q)
			3'd1:    fetch_addr = pwmre_pkg::ADDR_MODE2;
			3'd2:    fetch_addr = pwmre_pkg::ADDR_PRESCALE;
			default: fetch_addr = pwmre_pkg::ADDR_CH_BASE + {ch_q, 2'b00}
				+ {6'd0, 2'(step_q - 3'd3)};
		endcase
	end

	always_comb begin
		mem_we = accept && (pwmre_pkg::func_t'(func) == pwmre_pkg::FUNC_DATA)
			&& (ptr_in_file || ptr_q == pwmre_pkg::ADDR_PRESCALE_BUS);
		waddr  = ptr_in_file ? ADDR_W'(ptr_q) : ADDR_W'(pwmre_pkg::ADDR_PRESCALE);
		mem_re = 1'b0;
		raddr  = ADDR_W'(fetch_addr);
		if (accept && pwmre_pkg::func_t'(func) == pwmre_pkg::FUNC_READ) begin
			mem_re = ptr_in_file;
			raddr  = ADDR_W'(ptr_q[3:0]);
		end else if (accept && pwmre_pkg::func_t'(func) == pwmre_pkg::FUNC_QUERY) begin
			mem_re = ch_ok;
			raddr  = ADDR_W'(pwmre_pkg::ADDR_MODE1);
		end else if (state_q == S_FETCH && step_q != 3'd7) begin
			mem_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= data_byte;
		end
		if (mem_re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (mem_re) begin
				rvalid_s1 <= valid_q[raddr];
			end
		end
	end

	// hand the gathered counts to the pulse unit as the last byte arrives
	assign pstart = (state_q == S_FETCH) && (step_q == 3'd7) && !sleep_q && outdrv_q;
	assign preq   = '{on_count: on_q, off_count: {rd_byte, off_lo_q}, prescale: ps_q};

	pwmre_pulse u_pulse (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pstart),
		.req    (preq),
		.done   (pdone),
		.pulse  (pvalue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ptr_q        <= '0;
			flag_q       <= 1'b0;
			seen_q       <= 1'b0;
			ch_q         <= '0;
			step_q       <= '0;
			sleep_q      <= 1'b0;
			outdrv_q     <= 1'b0;
			ps_q         <= '0;
			on_q         <= '0;
			off_lo_q     <= '0;
			rsp_valid_q  <= 1'b0;
			read_data_q  <= '0;
			pulse_us_q   <= '0;
			write_seen_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						read_data_q  <= 8'd0;
						pulse_us_q   <= 16'd0;
						write_seen_q <= flag_q;
						unique case (pwmre_pkg::func_t'(func))
							pwmre_pkg::FUNC_SET_PTR: begin
								ptr_q        <= data_byte;
								flag_q       <= 1'b1;
								write_seen_q <= 1'b1;
								rsp_valid_q  <= 1'b1;
							end
							pwmre_pkg::FUNC_DATA: begin
								ptr_q       <= ptr_q + 8'd1;
								rsp_valid_q <= 1'b1;
							end
							pwmre_pkg::FUNC_READ: begin
								if (ptr_in_file) begin
									state_q <= S_READ;
								end else begin
									read_data_q <= pwmre_pkg::READ_MISS;
									rsp_valid_q <= 1'b1;
								end
							end
							pwmre_pkg::FUNC_QUERY: begin
								// report the flag, then clear it even for a bad channel
								flag_q <= 1'b0;
								seen_q <= flag_q;
								if (ch_ok) begin
									ch_q    <= channel[5:0];
									step_q  <= 3'd1;
									state_q <= S_FETCH;
								end else begin
									pulse_us_q  <= pwmre_pkg::PULSE_INVALID;
									rsp_valid_q <= 1'b1;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_READ: begin
					read_data_q <= rd_byte;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FETCH: begin
					step_q <= step_q + 3'd1;
					unique case (step_q)
						3'd1: sleep_q      <= rd_byte[pwmre_pkg::SLEEP_BIT];
						3'd2: outdrv_q     <= rd_byte[pwmre_pkg::OUTDRV_BIT];
						3'd3: ps_q         <= rd_byte;
						3'd4: on_q[7:0]    <= rd_byte;
						3'd5: on_q[15:8]   <= rd_byte;
						3'd6: off_lo_q     <= rd_byte;
						default: begin
							if (pstart) begin
								state_q <= S_CALC;
							end else begin
								read_data_q  <= 8'd0;
								pulse_us_q   <= 16'd0;
								write_seen_q <= seen_q;
								rsp_valid_q  <= 1'b1;
								state_q      <= S_IDLE;
							end
						end
					endcase
				end
				S_CALC: begin
					if (pdone) begin
						read_data_q  <= 8'd0;
						pulse_us_q   <= pvalue;
						write_seen_q <= seen_q;
						rsp_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_data  = read_data_q;
	assign pulse_us   = pulse_us_q;
	assign write_seen = write_seen_q;

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		pdone |-> state_q == S_CALC)
		else $error("pulse unit finished outside of a query");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("register file written and read in the same cycle");

	a_query_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pwmre_pkg::func_t'(func) == pwmre_pkg::FUNC_QUERY |=> !flag_q)
		else $error("write flag not cleared by query");

	a_ptr_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pwmre_pkg::func_t'(func) == pwmre_pkg::FUNC_DATA
		|=> ptr_q == $past(ptr_q) + 8'd1)
		else $error("pointer did not advance on data write");

	a_result_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !rsp_valid_q || rsp_ready || $past(rsp_valid_q) == 1'b1)
		else $error("result register occupied while a transaction is in flight");

endmodule
`default_nettype wire

// File: test/tb_pwm_controller_register_emulator.sv
// Testbench for the PWM register emulator: directed and random requests, scoreboard checking.
`timescale 1ns / 1ps
module tb_pwm_controller_register_emulator;

	localparam int NUM_CH     = 16;
	localparam int FILE_BYTES = 6 + 4 * NUM_CH;
	localparam int RAND_ITEMS = 950;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0]  rd;
		logic [15:0] pulse;
		logic        seen;
	} pwm_result_t;

	// Register file predictor plus queue of pending responses.
	class pwm_reg_scoreboard;
		logic [7:0]  reg_file [FILE_BYTES];
		logic [7:0]  reg_ptr;
		bit          wr_flag;
		pwm_result_t expected_rsp [$];
		int          errors;
		int          checked;
		int          func_count [4];
		int          live_pulses;
		int          invalid_queries;

		function new();
			foreach (reg_file[i]) reg_file[i] = 8'h00;
			reg_ptr = 8'h00;
			wr_flag = 1'b0;
			errors = 0;
			checked = 0;
			live_pulses = 0;
			invalid_queries = 0;
			foreach (func_count[i]) func_count[i] = 0;
		endfunction

		function logic [15:0] predict_pulse(logic [7:0] ch);
			logic [31:0] on_cnt, off_cnt, scale, prod;
			int base;
			if (ch >= NUM_CH)
				return pwmre_pkg::PULSE_INVALID;
			if (reg_file[pwmre_pkg::ADDR_MODE1][pwmre_pkg::SLEEP_BIT]
				|| !reg_file[pwmre_pkg::ADDR_MODE2][pwmre_pkg::OUTDRV_BIT])
				return 16'h0000;
			base = pwmre_pkg::ADDR_CH_BASE + 4 * ch;
			on_cnt  = {16'h0000, reg_file[base + 1], reg_file[base]};
			off_cnt = {16'h0000, reg_file[base + 3], reg_file[base + 2]};
			scale   = {24'h000000, reg_file[pwmre_pkg::ADDR_PRESCALE]} + 32'd1;
			prod    = (off_cnt - on_cnt) * scale;
			prod    = prod / 32'd25;
			return prod[15:0];
		endfunction

		function void note_request(pwmre_pkg::func_t f, logic [7:0] d, logic [7:0] c);
			pwm_result_t r;
			r = '0;
			func_count[f]++;
			case (f)
				pwmre_pkg::FUNC_SET_PTR: begin
					reg_ptr = d;
					wr_flag = 1'b1;
				end
				pwmre_pkg::FUNC_DATA: begin
					if (reg_ptr < FILE_BYTES)
						reg_file[reg_ptr] = d;
					else if (reg_ptr == pwmre_pkg::ADDR_PRESCALE_BUS)
						reg_file[pwmre_pkg::ADDR_PRESCALE] = d;
					reg_ptr = reg_ptr + 8'd1;
				end
				pwmre_pkg::FUNC_READ: begin
					r.rd = (reg_ptr < FILE_BYTES) ? reg_file[reg_ptr[3:0]]
						: pwmre_pkg::READ_MISS;
				end
				default: begin
					r.pulse = predict_pulse(c);
					if (c >= NUM_CH)
						invalid_queries++;
					else if (r.pulse != 16'h0000)
						live_pulses++;
				end
			endcase
			r.seen = wr_flag;
			// a query reports the flag, then clears it
			if (f == pwmre_pkg::FUNC_QUERY)
				wr_flag = 1'b0;
			expected_rsp.push_back(r);
		endfunction

		function void report_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t ns: %s", $realtime, msg);
		endfunction

		function void check_response(logic [7:0] rd, logic [15:0] pu, logic ws);
			pwm_result_t e;
			if (expected_rsp.size() == 0) begin
				report_error($sformatf("response with none pending: rd=%02h pulse=%04h seen=%0b",
					rd, pu, ws));
				return;
			end
			e = expected_rsp.pop_front();
			checked++;
			if (rd !== e.rd || pu !== e.pulse || ws !== e.seen)
				report_error($sformatf({"mismatch: expected rd=%02h pulse=%04h seen=%0b, ",
					"got rd=%02h pulse=%04h seen=%0b"}, e.rd, e.pulse, e.seen, rd, pu, ws));
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  func;
	logic [7:0]  data_byte;
	logic [7:0]  channel;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [7:0]  read_data;
	logic [15:0] pulse_us;
	logic        write_seen;

	pwm_reg_scoreboard sb;
	int req_sent;
	int idle_pct;
	int stall_pct;
	bit hold_request;
	int holds_done;

	pwm_controller_register_emulator #(
		.CHANNELS(NUM_CH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.func       (func),
		.data_byte  (data_byte),
		.channel    (channel),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.read_data  (read_data),
		.pulse_us   (pulse_us),
		.write_seen (write_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_pwm_controller_register_emulator: FAIL");
		$finish;
	end

	// Check responses before noting requests of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_response(read_data, pulse_us, write_seen);
			if (req_valid && req_ready)
				sb.note_request(pwmre_pkg::func_t'(func), data_byte, channel);
		end
	end

	// Response side: random stalls, plus a long hold-off on request.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic push_req(pwmre_pkg::func_t f, logic [7:0] d, logic [7:0] c);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		req_valid <= 1'b1;
		func      <= f;
		data_byte <= d;
		channel   <= c;
		do @(posedge clk); while (!req_ready);
		req_sent++;
	endtask

	task automatic program_channel(logic [7:0] ch);
		logic [15:0] on_cnt, off_cnt;
		on_cnt = 16'($urandom_range(0, 4095));
		if ($urandom_range(0, 3) != 0)
			off_cnt = 16'($urandom_range(on_cnt, 4095));
		else begin
			on_cnt  = 16'($urandom_range(0, 65535));
			off_cnt = 16'($urandom_range(0, 65535));
		end
		push_req(pwmre_pkg::FUNC_SET_PTR, pwmre_pkg::ADDR_CH_BASE + 8'(4 * ch),
			8'($urandom_range(0, 255)));
		push_req(pwmre_pkg::FUNC_DATA, on_cnt[7:0], 8'($urandom_range(0, 255)));
		push_req(pwmre_pkg::FUNC_DATA, on_cnt[15:8], 8'($urandom_range(0, 255)));
		push_req(pwmre_pkg::FUNC_DATA, off_cnt[7:0], 8'($urandom_range(0, 255)));
		push_req(pwmre_pkg::FUNC_DATA, off_cnt[15:8], 8'($urandom_range(0, 255)));
	endtask

	task automatic random_sequence();
		int pick, n;
		logic [7:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			v = 8'($urandom_range(0, NUM_CH - 1));
			program_channel(v);
			if ($urandom_range(0, 1))
				push_req(pwmre_pkg::FUNC_QUERY, 8'($urandom_range(0, 255)), v);
		end else if (pick < 40) begin
			// mostly awake with outputs driven, so queries give real widths
			push_req(pwmre_pkg::FUNC_SET_PTR, pwmre_pkg::ADDR_MODE1,
				8'($urandom_range(0, 255)));
			v = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) < 7)
				v[pwmre_pkg::SLEEP_BIT] = 1'b0;
			push_req(pwmre_pkg::FUNC_DATA, v, 8'($urandom_range(0, 255)));
			v = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) < 8)
				v[pwmre_pkg::OUTDRV_BIT] = 1'b1;
			push_req(pwmre_pkg::FUNC_DATA, v, 8'($urandom_range(0, 255)));
		end else if (pick < 47) begin
			push_req(pwmre_pkg::FUNC_SET_PTR,
				$urandom_range(0, 1) ? pwmre_pkg::ADDR_PRESCALE_BUS : pwmre_pkg::ADDR_PRESCALE,
				8'($urandom_range(0, 255)));
			push_req(pwmre_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 60) begin
			if ($urandom_range(0, 9) < 7)
				push_req(pwmre_pkg::FUNC_SET_PTR,
					8'($urandom_range(0, 9) < 7 ? $urandom_range(0, FILE_BYTES - 1)
					: $urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			n = $urandom_range(1, 3);
			repeat (n) push_req(pwmre_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 82) begin
			v = 8'(($urandom_range(0, 9) < 8) ? $urandom_range(0, NUM_CH - 1)
				: $urandom_range(0, 255));
			push_req(pwmre_pkg::FUNC_QUERY, 8'($urandom_range(0, 255)), v);
		end else if (pick < 90) begin
			push_req(pwmre_pkg::FUNC_SET_PTR, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			n = $urandom_range(1, 6);
			repeat (n) push_req(pwmre_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else begin
			push_req(pwmre_pkg::func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int phase;
		int directed;
		sb = new();
		req_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 1'b0;
		holds_done = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		func = pwmre_pkg::FUNC_SET_PTR;
		data_byte = 8'h00;
		channel = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, writes without a pointer byte, prescale redirect
		push_req(pwmre_pkg::FUNC_READ, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'hFF);
		push_req(pwmre_pkg::FUNC_DATA, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'h04, 8'h00);
		push_req(pwmre_pkg::FUNC_SET_PTR, pwmre_pkg::ADDR_PRESCALE_BUS, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'hFF, 8'h00);
		// pointer now 0xFF: byte dropped, pointer wraps to zero
		push_req(pwmre_pkg::FUNC_DATA, 8'hAA, 8'h00);
		push_req(pwmre_pkg::FUNC_READ, 8'hFF, 8'hFF);
		push_req(pwmre_pkg::FUNC_SET_PTR, pwmre_pkg::ADDR_CH_BASE, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'hFF, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'h0F, 8'h00);
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_SET_PTR, pwmre_pkg::ADDR_CH_BASE + 8'(4 * (NUM_CH - 1)),
			8'h00);
		repeat (2) push_req(pwmre_pkg::FUNC_DATA, 8'hFF, 8'h00);
		repeat (2) push_req(pwmre_pkg::FUNC_DATA, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'(NUM_CH - 1));
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'(NUM_CH));
		push_req(pwmre_pkg::FUNC_SET_PTR, 8'(FILE_BYTES), 8'h00);
		push_req(pwmre_pkg::FUNC_READ, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_SET_PTR, 8'(FILE_BYTES - 1), 8'h00);
		push_req(pwmre_pkg::FUNC_READ, 8'h00, 8'h00);
		push_req(pwmre_pkg::FUNC_SET_PTR, pwmre_pkg::ADDR_MODE1, 8'h00);
		push_req(pwmre_pkg::FUNC_DATA, 8'h10, 8'h00);
		push_req(pwmre_pkg::FUNC_QUERY, 8'h00, 8'h00);
		directed = req_sent;

		// random: no idling, sender idle, receiver stall with long hold-off, both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; hold_request = 1'b1; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			while (req_sent - directed < (RAND_ITEMS * (phase + 1)) / 4)
				random_sequence();
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Covered %0d requests: %0d pointer sets, %0d writes, %0d reads, %0d queries",
			req_sent, sb.func_count[pwmre_pkg::FUNC_SET_PTR], sb.func_count[pwmre_pkg::FUNC_DATA],
			sb.func_count[pwmre_pkg::FUNC_READ], sb.func_count[pwmre_pkg::FUNC_QUERY]);
		$display("%0d nonzero pulse widths, %0d invalid channels, %0d long hold-offs, %0d checked",
			sb.live_pulses, sb.invalid_queries, holds_done, sb.checked);
		if (sb.errors == 0)
			$display("tb_pwm_controller_register_emulator: PASS");
		else begin
			$display("%0d mismatches in total", sb.errors);
			$display("tb_pwm_controller_register_emulator: FAIL");
		end
		$finish;
	end
endmodule
